FILE: src/bmp_pkg.sv
// Shared constants and types for the binomial-mod-prime unit.
package bmp_pkg;
  localparam int unsigned MaxR = 4096;
  localparam int unsigned IdxW = $clog2(MaxR + 1);
  localparam int unsigned ValW = 30;
  localparam int unsigned NW = 31;
  localparam logic [ValW-1:0] PMod = 30'd1000000007;

  typedef struct packed {
    logic start;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
  } mul_req_t;
endpackage

FILE: src/bmp_mulmod.sv
// Bit-serial modular multiplier, one bit of b per cycle, MSB first.
module bmp_mulmod import bmp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  mul_req_t        req,
  output logic            done,
  output logic [ValW-1:0] res
);
  logic [ValW-1:0] a;
  logic [ValW-1:0] b;
  logic [ValW-1:0] acc;
  logic [4:0]      cnt;
  logic            run;
  logic [ValW+1:0] s0;
  logic [ValW+1:0] s1;
  logic [ValW+1:0] s2;

  always_comb begin
    s0 = {1'b0, acc, 1'b0} + (b[ValW-1] ? {2'b00, a} : '0);
    s1 = (s0 >= {2'b00, PMod}) ? s0 - {2'b00, PMod} : s0;
    s2 = (s1 >= {2'b00, PMod}) ? s1 - {2'b00, PMod} : s1;
  end

  assign res = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a <= req.a;
        b <= req.b;
        acc <= '0;
        cnt <= 5'(ValW - 1);
        run <= 1'b1;
      end else if (run) begin
        acc <= s2[ValW-1:0];
        b <= {b[ValW-2:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/bmp_divider.sv
// Restoring divider: prime divided by a table index, one quotient bit per cycle.
module bmp_divider import bmp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IdxW-1:0] divisor,
  output logic            done,
  output logic [ValW-1:0] quo,
  output logic [IdxW-1:0] rem
);
  logic [ValW-1:0] dvd;
  logic [IdxW-1:0] d;
  logic [4:0]      cnt;
  logic            run;
  logic [IdxW:0]   t;
  logic            ge;

  always_comb begin
    t = {rem, dvd[ValW-1]};
    ge = (t >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd <= PMod;
        d <= divisor;
        rem <= '0;
        quo <= '0;
        cnt <= 5'(ValW - 1);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? IdxW'(t - {1'b0, d}) : t[IdxW-1:0];
        quo <= {quo[ValW-2:0], ge};
        dvd <= {dvd[ValW-2:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/binomial_mod_prime_unit.sv
// Top level: sequencer, inverse-table memory, divider and modular multiplier.
// A request with r > n or r > MaxR is answered in the cycle after it is accepted. Otherwise
// the unit builds inv[2..r], each inverse taking a divide, two multiplies and sequencing
// steps, then takes the r factors of n, each with a multiply and a check.
// One request at a time: busy is high until the done strobe, and the next request may be
// accepted in the done cycle. The receiver cannot stall. Sync reset to idle; table not cleared.
module binomial_mod_prime_unit import bmp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [NW-1:0]   total_count,
  input  logic [NW-1:0]   chosen_count,
  output logic            done,
  output logic [ValW-1:0] coefficient,
  output logic            limit_exceeded
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK_I, S_DIV, S_READ, S_LAUNCH_T, S_MUL_T, S_MUL_ACC, S_CHECK_K, S_MUL_N
  } state_t;

  state_t state;

  // Request registers.
  logic [NW-1:0]   n;
  logic [IdxW-1:0] r;
  logic [IdxW-1:0] idx;   // next inverse to build
  logic [IdxW-1:0] k;     // factors of n taken so far
  logic [ValW-1:0] acc;   // running product
  logic [ValW-1:0] q;
  logic [IdxW-1:0] m;

  // Inverse table: one write port, one registered read port.
  logic [ValW-1:0] inv_mem [MaxR+1];
  logic [ValW-1:0] rd_data;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [ValW-1:0] mem_wdata;

  logic            div_start;
  logic            div_done;
  logic [ValW-1:0] div_quo;
  logic [IdxW-1:0] div_rem;
  mul_req_t        mul_req;
  logic            mul_done;
  logic [ValW-1:0] mul_res;

  logic [ValW-1:0] inv_new;
  logic [NW-1:0]   diff;
  logic [NW-1:0]   diff1;
  logic [ValW-1:0] term;
  logic            accept;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  // inv[i] = P - t, folded to zero when t is zero.
  assign inv_new = (mul_res == '0) ? '0 : PMod - mul_res;

  // (n - k) mod P: n < 3P, so at most two subtractions.
  always_comb begin
    diff = n - NW'(k);
    diff1 = (diff >= {PMod, 1'b0}) ? diff - {PMod, 1'b0} : diff;
    term = (diff1 >= {1'b0, PMod}) ? ValW'(diff1 - {1'b0, PMod}) : diff1[ValW-1:0];
  end

  // Seed inv[1] at accept; store each fresh inverse when its multiply ends.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = idx;
    mem_wdata = inv_new;
    if (accept) begin
      mem_we = 1'b1;
      mem_waddr = IdxW'(1);
      mem_wdata = ValW'(1);
    end else if (state == S_MUL_T && mul_done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      inv_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= inv_mem[m];
  end

  bmp_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (idx),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  bmp_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .res  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      div_start <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      done <= 1'b0;
      div_start <= 1'b0;
      mul_req.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            n <= total_count;
            r <= chosen_count[IdxW-1:0];
            idx <= IdxW'(2);
            k <= '0;
            acc <= ValW'(1);
            if (chosen_count > total_count) begin
              done <= 1'b1;
              coefficient <= '0;
              limit_exceeded <= 1'b0;
            end else if (chosen_count > NW'(MaxR)) begin
              done <= 1'b1;
              coefficient <= '0;
              limit_exceeded <= 1'b1;
            end else begin
              state <= S_CHECK_I;
            end
          end
        end
        S_CHECK_I: begin
          if (idx > r) begin
            state <= S_CHECK_K;
          end else begin
            div_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            q <= div_quo;
            m <= div_rem;
            state <= S_READ;
          end
        end
        S_READ: begin
          // Table read of inv[m] lands at the end of this cycle.
          state <= S_LAUNCH_T;
        end
        S_LAUNCH_T: begin
          mul_req <= '{start: 1'b1, a: q, b: rd_data};
          state <= S_MUL_T;
        end
        S_MUL_T: begin
          if (mul_done) begin
            mul_req <= '{start: 1'b1, a: acc, b: inv_new};
            state <= S_MUL_ACC;
          end
        end
        S_MUL_ACC: begin
          if (mul_done) begin
            acc <= mul_res;
            idx <= idx + IdxW'(1);
            state <= S_CHECK_I;
          end
        end
        S_CHECK_K: begin
          if (k == r) begin
            done <= 1'b1;
            coefficient <= acc;
            limit_exceeded <= 1'b0;
            state <= S_IDLE;
          end else begin
            mul_req <= '{start: 1'b1, a: acc, b: term};
            state <= S_MUL_N;
          end
        end
        S_MUL_N: begin
          if (mul_done) begin
            acc <= mul_res;
            k <= k + IdxW'(1);
            state <= S_CHECK_K;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept && total_count >= chosen_count && chosen_count <= NW'(MaxR) |=> busy)
    else $error("accepted request did not raise busy");
  a_limit_zero: assert property (@(posedge clk) disable iff (rst)
    done && limit_exceeded |-> coefficient == '0)
    else $error("limit flagged with nonzero coefficient");
  a_residue: assert property (@(posedge clk) disable iff (rst)
    done |-> coefficient < PMod)
    else $error("coefficient not reduced");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");
`endif
endmodule
